### rtl/lacc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacc_pkg
// Shared codes and types of the age-counter cache: operation codes, register
// map of the configuration port and the result flag group.
// ----------------------------------------------------------------------------
package lacc_pkg;

	localparam int CFG_W    = 5;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int SLOT_W   = 4;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// register index, taken from paddr[2]
	localparam logic [0:0] REG_ENTRIES_IN_USE = 1'd0;

	typedef struct packed {
		logic hit;
		logic stored;
		logic evicted;
	} lacc_flags_t;

endpackage

### rtl/lacc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module lacc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/lacc_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacc_engine
// Scan and update engine: walks the slots in use through the entry RAM,
// ages valid slots on insert, finds the match, the first free slot and the
// oldest slot, then writes back the target of a hit or a store.
// ----------------------------------------------------------------------------
module lacc_engine #(
	parameter int ENTRIES     = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32,
	parameter int AGE_WIDTH   = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       req_valid,
	output logic                                       req_ready,
	input  logic                                       req_op,
	input  logic [KEY_WIDTH-1:0]                       req_key,
	input  logic [VALUE_WIDTH-1:0]                     req_value,
	input  logic [$clog2(ENTRIES+1)-1:0]               req_n,
	output logic                                       res_valid,
	input  logic                                       res_ready,
	output lacc_pkg::lacc_flags_t                      res_flags,
	output logic [VALUE_WIDTH-1:0]                     res_data,
	output logic [KEY_WIDTH-1:0]                       res_ev_key,
	output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] res_slot
);
	import lacc_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
	localparam int MEM_W = KEY_WIDTH + VALUE_WIDTH + AGE_WIDTH;
	localparam logic [AGE_WIDTH-1:0] AGE_ONE = AGE_WIDTH'(1);
	localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;
	localparam logic [1:0] ST_RESP   = 2'd3;

	logic [1:0]             state_q;
	logic                   op_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [CNT_W-1:0]       n_q;
	logic [CNT_W-1:0]       rd_cnt_q;
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   found_q;
	logic [IDX_W-1:0]       match_idx_q;
	logic [VALUE_WIDTH-1:0] match_val_q;
	logic                   free_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic [AGE_WIDTH-1:0]   old_age_q;
	logic [IDX_W-1:0]       old_idx_q;
	logic [KEY_WIDTH-1:0]   old_key_q;
	logic [ENTRIES-1:0]     valid_q;

	lacc_flags_t            flags_q;
	logic [VALUE_WIDTH-1:0] data_q;
	logic [KEY_WIDTH-1:0]   ev_key_q;
	logic [IDX_W-1:0]       slot_q;

	logic                   rd_en;
	logic [MEM_W-1:0]       rd_data;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [MEM_W-1:0]       wr_data;

	logic [KEY_WIDTH-1:0]   e_key;
	logic [VALUE_WIDTH-1:0] e_val;
	logic [AGE_WIDTH-1:0]   e_age;
	logic                   e_valid;
	logic [AGE_WIDTH-1:0]   e_aged;
	logic                   e_match;

	lacc_flags_t            upd_flags;
	logic                   upd_write;
	logic [IDX_W-1:0]       upd_idx;
	logic [VALUE_WIDTH-1:0] upd_val;
	logic [VALUE_WIDTH-1:0] upd_data;
	logic [KEY_WIDTH-1:0]   upd_ev_key;

	assign req_ready  = (state_q == ST_IDLE);
	assign res_valid  = (state_q == ST_RESP);
	assign res_flags  = flags_q;
	assign res_data   = data_q;
	assign res_ev_key = ev_key_q;
	assign res_slot   = slot_q;

	assign rd_en = (state_q == ST_SCAN) && (rd_cnt_q < n_q);

	assign e_age   = rd_data[AGE_WIDTH-1:0];
	assign e_val   = rd_data[AGE_WIDTH +: VALUE_WIDTH];
	assign e_key   = rd_data[AGE_WIDTH + VALUE_WIDTH +: KEY_WIDTH];
	assign e_valid = valid_q[idx_s1];
	assign e_aged  = (e_age == AGE_MAX) ? e_age : e_age + AGE_ONE;
	assign e_match = e_valid && (e_key == key_q);

	always_comb begin
		upd_flags  = '0;
		upd_write  = 1'b0;
		upd_idx    = match_idx_q;
		upd_val    = value_q;
		upd_data   = '0;
		upd_ev_key = '0;
		if (op_q == OP_LOOKUP) begin
			if (found_q) begin
				upd_flags.hit = 1'b1;
				upd_write     = 1'b1;
				upd_val       = match_val_q;
				upd_data      = match_val_q;
			end
		end else if (n_q != '0) begin
			upd_flags.stored = 1'b1;
			upd_write        = 1'b1;
			if (found_q) begin
				upd_flags.hit = 1'b1;
			end else if (free_q) begin
				upd_idx = free_idx_q;
			end else begin
				upd_flags.evicted = 1'b1;
				upd_ev_key        = old_key_q;
				upd_idx           = old_idx_q;
			end
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s1;
		wr_data = {e_key, e_val, e_aged};
		if (state_q == ST_SCAN) begin
			wr_en = vld_s1 && e_valid && (op_q == OP_INSERT);
		end else if (state_q == ST_UPDATE) begin
			wr_en   = upd_write;
			wr_addr = upd_idx;
			wr_data = {key_q, upd_val, AGE_ONE};
		end
	end

	lacc_ram #(
		.WIDTH(MEM_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_cnt_q[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			valid_q  <= '0;
			vld_s1   <= 1'b0;
			rd_cnt_q <= '0;
		end else begin
			vld_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						rd_cnt_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
					end else if (!vld_s1) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (upd_write) begin
						valid_q[upd_idx] <= 1'b1;
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			op_q    <= req_op;
			key_q   <= req_key;
			value_q <= req_value;
			n_q     <= req_n;
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end
		if (state_q == ST_SCAN && vld_s1) begin
			idx_s1 <= rd_cnt_q[IDX_W-1:0];
			if (e_match && !found_q) begin
				found_q     <= 1'b1;
				match_idx_q <= idx_s1;
				match_val_q <= e_val;
			end
			if (!e_valid && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
			if (idx_s1 == '0 || e_aged > old_age_q) begin
				old_age_q <= e_aged;
				old_idx_q <= idx_s1;
				old_key_q <= e_key;
			end
		end else begin
			idx_s1 <= rd_cnt_q[IDX_W-1:0];
		end
		if (state_q == ST_UPDATE) begin
			flags_q  <= upd_flags;
			data_q   <= upd_data;
			ev_key_q <= upd_ev_key;
			slot_q   <= upd_write ? upd_idx : '0;
		end
	end

endmodule

### rtl/lru_age_counter_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_age_counter_cache
// Fully associative cache with one age counter per slot, least recently
// used replacement, APB register for the number of slots in use.
//
//   port group   direction  word contents (low bit first)
//   s_axis_*     in         tdata: key, value; tuser: operation
//   m_axis_*     out        tdata: hit, data, stored, evicted, evicted_key, slot
//   APB          in/out     reg 0 at 0x0: entries_in_use[4:0]
//
// Items are handled one at a time: the entry RAM is read once per slot in
// use, in sequence, the read pipeline drains, then the target slot is
// written back, the word is handed over and only then is the next item
// taken. A finished word waits in the output register while the next item is
// taken; a second finished word holds the engine and the input until the
// first drains. Reset clears all valid bits and the register at once; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_age_counter_cache #(
	parameter int ENTRIES     = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32,
	parameter int AGE_WIDTH   = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// key, value
	input  logic [((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// operation
	input  logic                                   s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// hit, data, stored, evicted, evicted_key, slot
	output logic [((VALUE_WIDTH + KEY_WIDTH + 7 + 7) / 8) * 8 - 1:0] m_axis_tdata,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [lacc_pkg::PADDR_W-1:0]           paddr,
	input  logic [lacc_pkg::PDATA_W-1:0]           pwdata,
	output logic [lacc_pkg::PDATA_W-1:0]           prdata,
	output logic                                   pready
);
	import lacc_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
	localparam int OUT_W = ((VALUE_WIDTH + KEY_WIDTH + 7 + 7) / 8) * 8;

	logic [CFG_W-1:0]       entries_q;
	logic [CNT_W-1:0]       n_use;
	logic                   req_ready;
	logic                   res_valid;
	logic                   res_ready;
	lacc_flags_t            res_flags;
	logic [VALUE_WIDTH-1:0] res_data;
	logic [KEY_WIDTH-1:0]   res_ev_key;
	logic [IDX_W-1:0]       res_slot;
	logic [OUT_W-1:0]       out_word;
	logic                   m_valid_q;
	logic [OUT_W-1:0]       m_data_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2:2] == REG_ENTRIES_IN_USE) ? PDATA_W'(entries_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& paddr[2:2] == REG_ENTRIES_IN_USE) begin
			entries_q <= pwdata[CFG_W-1:0];
		end
	end

	assign n_use = (int'(entries_q) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(entries_q);

	lacc_engine #(
		.ENTRIES    (ENTRIES),
		.KEY_WIDTH  (KEY_WIDTH),
		.VALUE_WIDTH(VALUE_WIDTH),
		.AGE_WIDTH  (AGE_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (req_ready),
		.req_op    (s_axis_tuser),
		.req_key   (s_axis_tdata[KEY_WIDTH-1:0]),
		.req_value (s_axis_tdata[KEY_WIDTH +: VALUE_WIDTH]),
		.req_n     (n_use),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_flags (res_flags),
		.res_data  (res_data),
		.res_ev_key(res_ev_key),
		.res_slot  (res_slot)
	);

	assign s_axis_tready = req_ready;
	assign res_ready     = !m_valid_q || m_axis_tready;

	always_comb begin
		out_word                                        = '0;
		out_word[0]                                     = res_flags.hit;
		out_word[1 +: VALUE_WIDTH]                      = res_data;
		out_word[VALUE_WIDTH + 1]                       = res_flags.stored;
		out_word[VALUE_WIDTH + 2]                       = res_flags.evicted;
		out_word[VALUE_WIDTH + 3 +: KEY_WIDTH]          = res_ev_key;
		out_word[VALUE_WIDTH + KEY_WIDTH + 3 +: SLOT_W] = SLOT_W'(res_slot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_data_q <= out_word;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

### rtl/lacc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacc_checker
// Port-level checks of the age-counter cache: one item in flight, held
// output words and consistent result flags.
// ----------------------------------------------------------------------------
module lacc_checker #(
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_axis_tvalid,
	input logic                                   s_axis_tready,
	input logic                                   m_axis_tvalid,
	input logic                                   m_axis_tready,
	input logic [((VALUE_WIDTH + KEY_WIDTH + 7 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

	localparam int STORED_BIT = VALUE_WIDTH + 1;
	localparam int EVICT_BIT  = VALUE_WIDTH + 2;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output word changed");

	a_evict_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[EVICT_BIT]
		|-> m_axis_tdata[STORED_BIT] && !m_axis_tdata[0])
		else $error("eviction without a store or with a hit");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[STORED_BIT] || !m_axis_tdata[0])
		|-> m_axis_tdata[VALUE_WIDTH:1] == '0)
		else $error("data returned outside a lookup hit");

endmodule

bind lru_age_counter_cache lacc_checker #(
	.KEY_WIDTH  (KEY_WIDTH),
	.VALUE_WIDTH(VALUE_WIDTH)
) u_lacc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
